// ===== rtl/nrpq_pkg.sv =====
// Shared types and constants for the neighbor resolution pending queue.
package nrpq_pkg;

  localparam int unsigned SLOTS_DEF   = 8;
  localparam int unsigned MAX_LEN_DEF = 1536;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned LEN_W       = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 1'b1;

  localparam logic OP_QUEUE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd1000;
  localparam logic [7:0]  MAX_RETRIES_RST    = 8'd3;

  typedef enum logic [2:0] {
    ACT_REJECT  = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_HELD    = 3'd2,
    ACT_SOLICIT = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_GIVEUP  = 3'd5,
    ACT_FULL    = 3'd6
  } action_e;

  typedef struct packed {
    logic [63:0]      addr_hi;
    logic [63:0]      addr_lo;
    logic [LEN_W-1:0] len;
    logic [31:0]      stamp;
    logic [7:0]       retries;
  } slot_entry_t;

  localparam int unsigned ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    action_e          act;
    logic [2:0]       slot;
    logic [63:0]      hi;
    logic [63:0]      lo;
    logic [LEN_W-1:0] len;
    logic [31:0]      drops;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic fin_decide;
    logic fin_solicit;
    logic flush;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;
    logic is_tick;
  } sts_t;

endpackage

// ===== rtl/neighbor_resolution_pending_queue_core.sv =====
// Top level: pending queue for frames awaiting IPv6 neighbor resolution.
// Steps: a queue item runs scan, tail, decide, solicit and flush; a tick item runs
// scan, tail and flush. The last result of an item shows in the first cycle in
// which busy is low again. No new item is taken while busy; the scan reads one
// slot of the slot RAM per cycle. Results cannot be stalled.
// Reset: busy flags, drop counter and configuration return to defaults at once.
module neighbor_resolution_pending_queue_core #(
  parameter int unsigned SLOTS   = nrpq_pkg::SLOTS_DEF,
  parameter int unsigned MAX_LEN = nrpq_pkg::MAX_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nrpq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nrpq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode_i,
  input  logic [63:0]                     addr_high_i,
  input  logic [63:0]                     addr_low_i,
  input  logic [15:0]                     length_in_i,
  input  logic                            neighbor_known_i,
  input  logic [31:0]                     now_ticks_i,
  input  logic [7:0]                      resolved_mask_i,
  output logic                            result_valid_o,
  output logic [2:0]                      action_o,
  output logic [2:0]                      slot_index_o,
  output logic [63:0]                     target_high_o,
  output logic [63:0]                     target_low_o,
  output logic [10:0]                     length_out_o,
  output logic [31:0]                     drops_so_far_o,
  output logic                            last_of_run_o
);

  nrpq_pkg::cmd_t    cmd;
  nrpq_pkg::sts_t    sts;
  nrpq_pkg::result_t res;

  nrpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  nrpq_datapath #(
    .SLOTS   (SLOTS),
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .addr_high_i      (addr_high_i),
    .addr_low_i       (addr_low_i),
    .length_in_i      (length_in_i),
    .neighbor_known_i (neighbor_known_i),
    .now_ticks_i      (now_ticks_i),
    .resolved_mask_i  (resolved_mask_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_valid_o   (result_valid_o),
    .result_o         (res),
    .last_of_run_o    (last_of_run_o)
  );

  assign action_o       = res.act;
  assign slot_index_o   = res.slot;
  assign target_high_o  = res.hi;
  assign target_low_o   = res.lo;
  assign length_out_o   = res.len;
  assign drops_so_far_o = res.drops;

endmodule

// ===== rtl/nrpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nrpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/nrpq_ctrl.sv =====
// Sequencer for the slot scan and the closing steps of each item.
module nrpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  nrpq_pkg::sts_t    sts_i,
  output nrpq_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_TAIL  = 6'b000100,
    S_FIN1  = 6'b001000,
    S_FIN2  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    busy_o            = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      // Last slot is evaluated here.
      S_TAIL: begin
        state_d = sts_i.is_tick ? S_FLUSH : S_FIN1;
      end
      S_FIN1: begin
        cmd_o.fin_decide = 1'b1;
        state_d          = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.fin_solicit = 1'b1;
        state_d           = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/nrpq_datapath.sv =====
// Slot store, busy flags, scan evaluation and result staging.
module nrpq_datapath #(
  parameter int unsigned SLOTS   = nrpq_pkg::SLOTS_DEF,
  parameter int unsigned MAX_LEN = nrpq_pkg::MAX_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nrpq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nrpq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              opcode_i,
  input  logic [63:0]                       addr_high_i,
  input  logic [63:0]                       addr_low_i,
  input  logic [15:0]                       length_in_i,
  input  logic                              neighbor_known_i,
  input  logic [31:0]                       now_ticks_i,
  input  logic [7:0]                        resolved_mask_i,
  input  nrpq_pkg::cmd_t                    cmd_i,
  output nrpq_pkg::sts_t                    sts_o,
  output logic                              result_valid_o,
  output nrpq_pkg::result_t                 result_o,
  output logic                              last_of_run_o
);

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(nrpq_pkg::MAX_RESULTS + 1);

  // Latched item
  logic        op_q;
  logic [63:0] ahi_q, alo_q;
  logic [15:0] len_q;
  logic        known_q;
  logic [31:0] now_q;
  logic [7:0]  mask_q;

  logic [31:0] retry_interval_q;
  logic [7:0]  max_retries_q;

  logic [SLOTS-1:0] busy_q, busy_d;
  logic [31:0]      drop_q, drop_d;

  logic [IDXW-1:0] rd_idx_q, eval_idx_q, free_idx_q;
  logic            eval_vld_q;
  logic            free_found_q, match_q;

  logic              pend_vld_q;
  nrpq_pkg::result_t pend_q, push_res;
  logic              push;
  logic [CNTW-1:0]   res_cnt_q;
  logic              out_vld_q, out_last_q;
  nrpq_pkg::result_t out_q;

  logic                     ram_we;
  logic [IDXW-1:0]          ram_waddr;
  nrpq_pkg::slot_entry_t    ram_wdata, rd_ent;
  logic [nrpq_pkg::ENTRY_W-1:0] ram_rdata;

  logic [SLOTS-1:0] res_vec;
  logic             ev_busy, ev_match, ev_due, ev_giveup, len_ok;
  logic [31:0]      elapsed;

  for (genvar g = 0; g < SLOTS; g++) begin : g_res
    if (g < 8) begin : g_lo
      assign res_vec[g] = mask_q[g];
    end else begin : g_hi
      assign res_vec[g] = 1'b0;
    end
  end

  assign rd_ent    = nrpq_pkg::slot_entry_t'(ram_rdata);
  assign ev_busy   = eval_vld_q & busy_q[eval_idx_q];
  assign ev_match  = ev_busy && (rd_ent.addr_hi == ahi_q) && (rd_ent.addr_lo == alo_q);
  assign elapsed   = now_q - rd_ent.stamp;
  assign ev_due    = elapsed >= retry_interval_q;
  assign ev_giveup = rd_ent.retries >= max_retries_q;
  assign len_ok    = (len_q != 16'd0) && (len_q <= 16'(MAX_LEN));

  assign sts_o.scan_last = rd_idx_q == IDXW'(SLOTS - 1);
  assign sts_o.is_tick   = op_q == nrpq_pkg::OP_TICK;

  always_comb begin
    busy_d    = busy_q;
    drop_d    = drop_q;
    push      = 1'b0;
    push_res  = '0;
    ram_we    = 1'b0;
    ram_waddr = eval_idx_q;
    ram_wdata = rd_ent;

    if (ev_busy && op_q == nrpq_pkg::OP_TICK) begin
      push_res.slot = 3'(eval_idx_q);
      push_res.hi   = rd_ent.addr_hi;
      push_res.lo   = rd_ent.addr_lo;
      if (res_vec[eval_idx_q]) begin
        busy_d[eval_idx_q] = 1'b0;
        push               = 1'b1;
        push_res.act       = nrpq_pkg::ACT_RELEASE;
        push_res.len       = rd_ent.len;
      end else if (ev_due) begin
        push = 1'b1;
        if (ev_giveup) begin
          drop_d             = drop_q + 32'd1;
          busy_d[eval_idx_q] = 1'b0;
          push_res.act       = nrpq_pkg::ACT_GIVEUP;
        end else begin
          ram_we          = 1'b1;
          ram_wdata.stamp = now_q;
          if (rd_ent.retries != 8'hFF) begin
            ram_wdata.retries = rd_ent.retries + 8'd1;
          end
          push_res.act = nrpq_pkg::ACT_SOLICIT;
        end
      end
    end

    if (cmd_i.fin_decide) begin
      push = 1'b1;
      if (!len_ok) begin
        push_res.act = nrpq_pkg::ACT_REJECT;
      end else if (known_q) begin
        push_res.act = nrpq_pkg::ACT_SEND;
      end else if (!free_found_q) begin
        drop_d       = drop_q + 32'd1;
        push_res.act = nrpq_pkg::ACT_FULL;
      end else begin
        ram_we             = 1'b1;
        ram_waddr          = free_idx_q;
        ram_wdata.addr_hi  = ahi_q;
        ram_wdata.addr_lo  = alo_q;
        ram_wdata.len      = len_q[nrpq_pkg::LEN_W-1:0];
        ram_wdata.stamp    = now_q;
        ram_wdata.retries  = 8'd0;
        busy_d[free_idx_q] = 1'b1;
        push_res.act       = nrpq_pkg::ACT_HELD;
        push_res.slot      = 3'(free_idx_q);
        push_res.hi        = ahi_q;
        push_res.lo        = alo_q;
      end
    end

    if (cmd_i.fin_solicit && len_ok && !known_q && free_found_q && !match_q) begin
      push          = 1'b1;
      push_res.act  = nrpq_pkg::ACT_SOLICIT;
      push_res.slot = 3'(free_idx_q);
      push_res.hi   = ahi_q;
      push_res.lo   = alo_q;
    end

    push_res.drops = drop_d;
  end

  logic push_ok;
  assign push_ok = push && (res_cnt_q < CNTW'(nrpq_pkg::MAX_RESULTS));

  nrpq_ram #(
    .WIDTH (nrpq_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_interval_q <= nrpq_pkg::RETRY_INTERVAL_RST;
      max_retries_q    <= nrpq_pkg::MAX_RETRIES_RST;
      busy_q           <= '0;
      drop_q           <= '0;
      rd_idx_q         <= '0;
      eval_vld_q       <= 1'b0;
      free_found_q     <= 1'b0;
      match_q          <= 1'b0;
      pend_vld_q       <= 1'b0;
      res_cnt_q        <= '0;
      out_vld_q        <= 1'b0;
      out_last_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nrpq_pkg::CFG_RETRY_INTERVAL: retry_interval_q <= cfg_data_i;
          nrpq_pkg::CFG_MAX_RETRIES:    max_retries_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      busy_q     <= busy_d;
      drop_q     <= drop_d;
      eval_vld_q <= cmd_i.rd_en;
      out_vld_q  <= 1'b0;
      if (cmd_i.load) begin
        rd_idx_q     <= '0;
        free_found_q <= 1'b0;
        match_q      <= 1'b0;
        pend_vld_q   <= 1'b0;
        res_cnt_q    <= '0;
      end else if (cmd_i.rd_en) begin
        rd_idx_q <= rd_idx_q + IDXW'(1);
      end
      if (eval_vld_q && op_q == nrpq_pkg::OP_QUEUE) begin
        if (ev_match) begin
          match_q <= 1'b1;
        end
        if (!busy_q[eval_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      // Hold one result back so the final one can be flagged.
      if (push_ok) begin
        pend_vld_q <= 1'b1;
        res_cnt_q  <= res_cnt_q + CNTW'(1);
        if (pend_vld_q) begin
          out_vld_q  <= 1'b1;
          out_last_q <= 1'b0;
        end
      end else if (cmd_i.flush && pend_vld_q) begin
        pend_vld_q <= 1'b0;
        out_vld_q  <= 1'b1;
        out_last_q <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      ahi_q   <= addr_high_i;
      alo_q   <= addr_low_i;
      len_q   <= length_in_i;
      known_q <= neighbor_known_i;
      now_q   <= now_ticks_i;
      mask_q  <= resolved_mask_i;
    end
    eval_idx_q <= rd_idx_q;
    if (eval_vld_q && op_q == nrpq_pkg::OP_QUEUE && !busy_q[eval_idx_q] && !free_found_q) begin
      free_idx_q <= eval_idx_q;
    end
    if (push_ok) begin
      pend_q <= push_res;
      if (pend_vld_q) begin
        out_q <= pend_q;
      end
    end else if (cmd_i.flush && pend_vld_q) begin
      out_q <= pend_q;
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;
  assign last_of_run_o  = out_last_q;

endmodule

// ===== rtl/nrpq_checker.sv =====
// Port-level checks for the pending queue core, bound to the top level.
module nrpq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [2:0] action_o,
  input logic       last_of_run_o
);

  // An accepted item keeps the block occupied in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after a transfer");

  // Without a new item the block stays idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !busy)
    else $error("busy rose without a transfer");

  // The final result of an item is never followed directly by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_run_o |=> !result_valid_o)
    else $error("result followed the final result of an item");

  // Reject, send-now and table-full are single results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (action_o == nrpq_pkg::ACT_REJECT || action_o == nrpq_pkg::ACT_SEND ||
                       action_o == nrpq_pkg::ACT_FULL) |-> last_of_run_o)
    else $error("single-result action not flagged as last");

endmodule

bind neighbor_resolution_pending_queue_core nrpq_checker u_nrpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .action_o       (action_o),
  .last_of_run_o  (last_of_run_o)
);
